[design/grbz_pkg.sv]
`timescale 1ns / 1ps
// grbz_pkg: constants, command codes, descriptor and memory request types
// shared by the glyph row blitter files other than grbz_ram. No dependencies.
package grbz_pkg;

	localparam int FRAME_WIDTH  = 1024;
	localparam int FRAME_HEIGHT = 512;
	localparam int TEXT_WIDTH   = 1024;
	localparam int TEXT_HEIGHT  = 16;
	localparam int GLYPH_WIDTH  = 8;
	localparam int GLYPH_HEIGHT = 8;

	localparam int CMD_W    = 2;
	localparam int BITS_W   = 8;
	localparam int ROW_W    = 3;
	localparam int ORG_W    = 12;
	localparam int RCOL_W   = 10;
	localparam int RROW_W   = 9;
	localparam int DATA_W   = 8;
	localparam int CLIP_W   = 8;
	localparam int ZOOM_W   = 3;
	localparam int ZCNT_W   = 2;
	localparam int KIND_W   = 2;

	localparam logic [CMD_W-1:0] CMD_DRAW  = 2'd0;
	localparam logic [CMD_W-1:0] CMD_READ  = 2'd1;
	localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

	localparam logic TGT_FRAME   = 1'b0;
	localparam logic TGT_TEXT    = 1'b1;
	localparam logic MODE_BYTE   = 1'b0;
	localparam logic MODE_NIBBLE = 1'b1;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 8;
	localparam logic [CFG_IDX_W-1:0] CFG_PIXEL_MODE = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_FG_COLOR   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_BG_COLOR   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_ZOOM_X     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_ZOOM_Y     = 3'd4;

	localparam logic [KIND_W-1:0] KIND_NOP   = 2'd0;
	localparam logic [KIND_W-1:0] KIND_DRAW  = 2'd1;
	localparam logic [KIND_W-1:0] KIND_READ  = 2'd2;
	localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd3;

	localparam logic [ZOOM_W-1:0] ZOOM_MIN = 3'd1;
	localparam logic [ZOOM_W-1:0] ZOOM_MAX = 3'd4;

	localparam logic [DATA_W-1:0] NIB_HI = 8'hf0;
	localparam logic [DATA_W-1:0] NIB_LO = 8'h0f;

	localparam int FRAME_DEPTH = FRAME_WIDTH * FRAME_HEIGHT;
	localparam int TEXT_DEPTH  = TEXT_WIDTH * TEXT_HEIGHT;
	localparam int FRAME_AW    = (FRAME_DEPTH > 1) ? $clog2(FRAME_DEPTH) : 1;
	localparam int TEXT_AW     = (TEXT_DEPTH > 1) ? $clog2(TEXT_DEPTH) : 1;
	localparam int AW          = (FRAME_AW > TEXT_AW) ? FRAME_AW : TEXT_AW;

	localparam int MAX_WID = (FRAME_WIDTH > TEXT_WIDTH) ? FRAME_WIDTH : TEXT_WIDTH;
	localparam int MAX_HGT = (FRAME_HEIGHT > TEXT_HEIGHT) ? FRAME_HEIGHT : TEXT_HEIGHT;
	localparam int MAX_DIM = (MAX_WID > MAX_HGT) ? MAX_WID : MAX_HGT;
	localparam int DIM_W   = $clog2(MAX_DIM + 1);

	// signed pixel coordinate: origin plus at most 4*GLYPH_WIDTH
	localparam int CRD_W   = ORG_W + 1;
	localparam int ROW_AW  = CRD_W + DIM_W + 1;
	localparam int BIT_CW  = (GLYPH_WIDTH > 1) ? $clog2(GLYPH_WIDTH) : 1;
	localparam int ZXG_W   = $clog2(4 * GLYPH_WIDTH + 1);
	localparam int RPROD_W = RROW_W + DIM_W + 1;

	localparam int QDEPTH = 2;
	localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;

	typedef struct packed {
		logic [KIND_W-1:0]      kind;
		logic                   target;
		logic                   mode;
		logic [DATA_W-1:0]      fg;
		logic [DATA_W-1:0]      bg;
		logic [GLYPH_WIDTH-1:0] bits;
		logic [ZOOM_W-1:0]      zx;
		logic [ZOOM_W-1:0]      zy;
		logic [CRD_W-1:0]       x0;
		logic [CRD_W-1:0]       y0;
		logic                   rd_ok;
		logic [AW-1:0]          rd_addr;
	} desc_t;

	typedef struct packed {
		logic              we_frame;
		logic              we_text;
		logic [AW-1:0]     waddr;
		logic [DATA_W-1:0] wdata;
		logic [AW-1:0]     raddr;
	} mem_req_t;

	function automatic logic [DIM_W-1:0] tgt_width(input logic t);
		return (t == TGT_TEXT) ? DIM_W'(TEXT_WIDTH) : DIM_W'(FRAME_WIDTH);
	endfunction

	function automatic logic [DIM_W-1:0] tgt_height(input logic t);
		return (t == TGT_TEXT) ? DIM_W'(TEXT_HEIGHT) : DIM_W'(FRAME_HEIGHT);
	endfunction

endpackage

[design/grbz_ram.sv]
`timescale 1ns / 1ps
// grbz_ram: generic simple dual-port RAM, one write and one registered read.
// No dependencies.
module grbz_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

[design/grbz_front.sv]
`timescale 1ns / 1ps
// grbz_front: configuration registers, input transfer and command classification.
// Depends on grbz_pkg.
module grbz_front (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [grbz_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [grbz_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  logic                                push,
	input  logic                                q_full,
	input  logic [grbz_pkg::CMD_W-1:0]          cmd,
	input  logic                                target,
	input  logic [grbz_pkg::BITS_W-1:0]         row_bits,
	input  logic [grbz_pkg::ROW_W-1:0]          row_index,
	input  logic signed [grbz_pkg::ORG_W-1:0]   org_x,
	input  logic signed [grbz_pkg::ORG_W-1:0]   org_y,
	input  logic [grbz_pkg::RCOL_W-1:0]         read_col,
	input  logic [grbz_pkg::RROW_W-1:0]         read_row,
	output logic                                q_wr,
	output grbz_pkg::desc_t                     q_desc
);

	logic                              pixel_mode_q;
	logic [grbz_pkg::DATA_W-1:0]       fg_color_q;
	logic [grbz_pkg::DATA_W-1:0]       bg_color_q;
	logic [grbz_pkg::ZOOM_W-1:0]       zoom_x_q;
	logic [grbz_pkg::ZOOM_W-1:0]       zoom_y_q;

	logic [grbz_pkg::ZOOM_W-1:0]       zx_c;
	logic [grbz_pkg::ZOOM_W-1:0]       zy_c;
	logic [grbz_pkg::ZXG_W-1:0]        zx_gw;
	logic [grbz_pkg::ZOOM_W+grbz_pkg::ROW_W-1:0] zy_row;
	logic [grbz_pkg::DIM_W-1:0]        w_sel;
	logic [grbz_pkg::DIM_W-1:0]        h_sel;
	logic [grbz_pkg::RPROD_W-1:0]      rd_prod;
	logic                              row_ok;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pixel_mode_q <= 1'b0;
			fg_color_q   <= '0;
			bg_color_q   <= '0;
			zoom_x_q     <= grbz_pkg::ZOOM_MIN;
			zoom_y_q     <= grbz_pkg::ZOOM_MIN;
		end else if (cfg_we) begin
			case (cfg_index)
				grbz_pkg::CFG_PIXEL_MODE: pixel_mode_q <= cfg_data[0];
				grbz_pkg::CFG_FG_COLOR:   fg_color_q   <= cfg_data[grbz_pkg::DATA_W-1:0];
				grbz_pkg::CFG_BG_COLOR:   bg_color_q   <= cfg_data[grbz_pkg::DATA_W-1:0];
				grbz_pkg::CFG_ZOOM_X:     zoom_x_q     <= cfg_data[grbz_pkg::ZOOM_W-1:0];
				grbz_pkg::CFG_ZOOM_Y:     zoom_y_q     <= cfg_data[grbz_pkg::ZOOM_W-1:0];
				default: ;
			endcase
		end
	end

	function automatic logic [grbz_pkg::ZOOM_W-1:0] clamp_zoom(
		input logic [grbz_pkg::ZOOM_W-1:0] z
	);
		if (z == '0) begin
			return grbz_pkg::ZOOM_MIN;
		end else if (z > grbz_pkg::ZOOM_MAX) begin
			return grbz_pkg::ZOOM_MAX;
		end
		return z;
	endfunction

	assign zx_c   = clamp_zoom(zoom_x_q);
	assign zy_c   = clamp_zoom(zoom_y_q);
	assign zx_gw  = grbz_pkg::ZXG_W'(zx_c) * grbz_pkg::ZXG_W'(grbz_pkg::GLYPH_WIDTH);
	assign zy_row = zy_c * row_index;
	assign w_sel  = grbz_pkg::tgt_width(target);
	assign h_sel  = grbz_pkg::tgt_height(target);
	assign rd_prod = grbz_pkg::RPROD_W'(read_row) * grbz_pkg::RPROD_W'(w_sel);
	assign row_ok = (32'(row_index) < grbz_pkg::GLYPH_HEIGHT);

	assign q_wr = push && !q_full;

	always_comb begin
		q_desc = '0;
		case (cmd)
			grbz_pkg::CMD_DRAW:  q_desc.kind = row_ok ? grbz_pkg::KIND_DRAW
			                                          : grbz_pkg::KIND_NOP;
			grbz_pkg::CMD_READ:  q_desc.kind = grbz_pkg::KIND_READ;
			grbz_pkg::CMD_CLEAR: q_desc.kind = grbz_pkg::KIND_CLEAR;
			default:             q_desc.kind = grbz_pkg::KIND_NOP;
		endcase
		q_desc.target  = target;
		q_desc.mode    = pixel_mode_q;
		q_desc.fg      = fg_color_q;
		q_desc.bg      = bg_color_q;
		q_desc.bits    = row_bits[grbz_pkg::GLYPH_WIDTH-1:0];
		q_desc.zx      = zx_c;
		q_desc.zy      = zy_c;
		// rightmost pixel of bit 0 sits at org_x + zoom_x*GLYPH_WIDTH;
		// the sweep starts there and walks left
		q_desc.x0      = grbz_pkg::CRD_W'(org_x) + grbz_pkg::CRD_W'(zx_gw);
		q_desc.y0      = grbz_pkg::CRD_W'(org_y) + grbz_pkg::CRD_W'(zy_row);
		q_desc.rd_ok   = (read_col < w_sel) && (read_row < h_sel);
		q_desc.rd_addr = grbz_pkg::AW'(rd_prod + grbz_pkg::RPROD_W'(read_col));
	end

endmodule

[design/grbz_queue.sv]
`timescale 1ns / 1ps
// grbz_queue: short descriptor queue between front and back.
// Depends on grbz_pkg.
module grbz_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            wr,
	input  grbz_pkg::desc_t wdesc,
	output logic            full,
	input  logic            rd,
	output grbz_pkg::desc_t rdesc,
	output logic            nempty
);

	grbz_pkg::desc_t                mem_q [grbz_pkg::QDEPTH];
	logic [grbz_pkg::QPTR_W-1:0]    wr_ptr_q;
	logic [grbz_pkg::QPTR_W-1:0]    rd_ptr_q;
	logic [grbz_pkg::QPTR_W:0]      cnt_q;

	function automatic logic [grbz_pkg::QPTR_W-1:0] ptr_inc(
		input logic [grbz_pkg::QPTR_W-1:0] p
	);
		return (p == grbz_pkg::QPTR_W'(grbz_pkg::QDEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	assign full   = (cnt_q == (grbz_pkg::QPTR_W + 1)'(grbz_pkg::QDEPTH));
	assign nempty = (cnt_q != '0);
	assign rdesc  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr) begin
			mem_q[wr_ptr_q] <= wdesc;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (wr) begin
				wr_ptr_q <= ptr_inc(wr_ptr_q);
			end
			if (rd) begin
				rd_ptr_q <= ptr_inc(rd_ptr_q);
			end
			case ({wr, rd})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

[design/grbz_back.sv]
`timescale 1ns / 1ps
// grbz_back: executes descriptors (pixel sweep, byte read, store clear) and
// holds the result register. Depends on grbz_pkg; drives the store RAMs.
module grbz_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          q_nempty,
	input  grbz_pkg::desc_t               q_desc,
	output logic                          q_rd,
	output grbz_pkg::mem_req_t            mem_req,
	input  logic [grbz_pkg::DATA_W-1:0]   frame_rdata,
	input  logic [grbz_pkg::DATA_W-1:0]   text_rdata,
	output logic                          empty,
	input  logic                          pop,
	output logic [grbz_pkg::DATA_W-1:0]   read_data,
	output logic [grbz_pkg::CLIP_W-1:0]   clipped_count
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_LOAD = 3'd1;
	localparam logic [2:0] ST_PIX  = 3'd2;
	localparam logic [2:0] ST_RMW  = 3'd3;
	localparam logic [2:0] ST_RD   = 3'd4;
	localparam logic [2:0] ST_RDW  = 3'd5;
	localparam logic [2:0] ST_CLR  = 3'd6;
	localparam logic [2:0] ST_DONE = 3'd7;

	logic [2:0]                          state_q;
	grbz_pkg::desc_t                     cur_q;

	logic signed [grbz_pkg::CRD_W-1:0]   x_q;
	logic signed [grbz_pkg::CRD_W-1:0]   y_q;
	logic signed [grbz_pkg::ROW_AW-1:0]  rowaddr_q;
	logic signed [grbz_pkg::ROW_AW-1:0]  rowbase_q;
	logic [grbz_pkg::BIT_CW-1:0]         b_q;
	logic [grbz_pkg::ZCNT_W-1:0]         i_q;
	logic [grbz_pkg::ZCNT_W-1:0]         j_q;
	logic [grbz_pkg::CLIP_W-1:0]         clip_q;
	logic [grbz_pkg::DATA_W-1:0]         res_data_q;
	logic [grbz_pkg::AW-1:0]             clr_q;

	logic [grbz_pkg::AW-1:0]             waddr_q;
	logic [grbz_pkg::DATA_W-1:0]         pix_q;
	logic                                odd_q;

	logic                                out_valid_q;
	logic [grbz_pkg::DATA_W-1:0]         out_data_q;
	logic [grbz_pkg::CLIP_W-1:0]         out_clip_q;

	logic [grbz_pkg::DIM_W-1:0]          w_cur;
	logic [grbz_pkg::DIM_W-1:0]          h_cur;
	logic signed [grbz_pkg::CRD_W-1:0]   x_off;
	logic signed [grbz_pkg::ROW_AW-1:0]  addr_full;
	logic [grbz_pkg::AW-1:0]             addr;
	logic                                in_b;
	logic [grbz_pkg::DATA_W-1:0]         pix;
	logic [grbz_pkg::DATA_W-1:0]         rdata_sel;
	logic [grbz_pkg::DATA_W-1:0]         merged;
	logic                                last_j;
	logic                                last_i;
	logic                                last_b;
	logic                                adv;
	logic                                out_load;
	logic                                clr_last;
	logic signed [grbz_pkg::ROW_AW-1:0]  y0_prod;

	assign w_cur = grbz_pkg::tgt_width(cur_q.target);
	assign h_cur = grbz_pkg::tgt_height(cur_q.target);

	assign in_b = !x_q[grbz_pkg::CRD_W-1] && (x_q < $signed({1'b0, w_cur}))
	           && !y_q[grbz_pkg::CRD_W-1] && (y_q < $signed({1'b0, h_cur}));
	assign x_off     = (cur_q.mode == grbz_pkg::MODE_NIBBLE) ? (x_q >>> 1) : x_q;
	assign addr_full = rowaddr_q + grbz_pkg::ROW_AW'(x_off);
	assign addr      = addr_full[grbz_pkg::AW-1:0];
	assign pix       = cur_q.bits[b_q] ? cur_q.fg : cur_q.bg;

	assign rdata_sel = (cur_q.target == grbz_pkg::TGT_TEXT) ? text_rdata : frame_rdata;
	assign merged    = odd_q ? ((rdata_sel & grbz_pkg::NIB_LO) | (pix_q & grbz_pkg::NIB_HI))
	                         : ((rdata_sel & grbz_pkg::NIB_HI) | (pix_q & grbz_pkg::NIB_LO));

	assign last_j = (grbz_pkg::ZOOM_W'(j_q) == cur_q.zy - grbz_pkg::ZOOM_W'(1));
	assign last_i = (grbz_pkg::ZOOM_W'(i_q) == cur_q.zx - grbz_pkg::ZOOM_W'(1));
	assign last_b = (b_q == grbz_pkg::BIT_CW'(grbz_pkg::GLYPH_WIDTH - 1));

	// a pixel finishes in ST_PIX unless it needs a nibble merge
	assign adv = ((state_q == ST_PIX) && !(in_b && (cur_q.mode == grbz_pkg::MODE_NIBBLE)))
	          || (state_q == ST_RMW);

	assign clr_last = (cur_q.target == grbz_pkg::TGT_TEXT)
	                ? (clr_q == grbz_pkg::AW'(grbz_pkg::TEXT_DEPTH - 1))
	                : (clr_q == grbz_pkg::AW'(grbz_pkg::FRAME_DEPTH - 1));

	assign y0_prod = grbz_pkg::ROW_AW'($signed(cur_q.y0)) * $signed({1'b0, w_cur});

	assign q_rd     = (state_q == ST_IDLE) && q_nempty;
	assign out_load = (state_q == ST_DONE) && (!out_valid_q || pop);

	always_comb begin
		logic we;
		we = 1'b0;
		mem_req       = '0;
		mem_req.raddr = cur_q.rd_addr;
		case (state_q)
			ST_PIX: begin
				mem_req.raddr = addr;
				if (in_b && (cur_q.mode == grbz_pkg::MODE_BYTE)) begin
					we            = 1'b1;
					mem_req.waddr = addr;
					mem_req.wdata = pix;
				end
			end
			ST_RMW: begin
				we            = 1'b1;
				mem_req.waddr = waddr_q;
				mem_req.wdata = merged;
			end
			ST_CLR: begin
				we            = 1'b1;
				mem_req.waddr = clr_q;
				mem_req.wdata = '0;
			end
			default: ;
		endcase
		mem_req.we_frame = we && (cur_q.target == grbz_pkg::TGT_FRAME);
		mem_req.we_text  = we && (cur_q.target == grbz_pkg::TGT_TEXT);
	end

	always_ff @(posedge clk) begin
		if (q_rd) begin
			cur_q <= q_desc;
		end
		if (state_q == ST_PIX) begin
			waddr_q <= addr;
			pix_q   <= pix;
			odd_q   <= x_q[0];
		end
		if (out_load) begin
			out_data_q <= res_data_q;
			out_clip_q <= clip_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			x_q         <= '0;
			y_q         <= '0;
			rowaddr_q   <= '0;
			rowbase_q   <= '0;
			b_q         <= '0;
			i_q         <= '0;
			j_q         <= '0;
			clip_q      <= '0;
			res_data_q  <= '0;
			clr_q       <= '0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (pop && out_valid_q) begin
				out_valid_q <= 1'b0;
			end

			if (adv) begin
				if (state_q == ST_PIX && !in_b) begin
					clip_q <= clip_q + 1'b1;
				end
				if (last_j) begin
					j_q       <= '0;
					y_q       <= $signed(cur_q.y0);
					rowaddr_q <= rowbase_q;
					x_q       <= x_q - 1'b1;
					if (last_i) begin
						i_q <= '0;
						b_q <= b_q + 1'b1;
					end else begin
						i_q <= i_q + 1'b1;
					end
				end else begin
					j_q       <= j_q + 1'b1;
					y_q       <= y_q + 1'b1;
					rowaddr_q <= rowaddr_q + grbz_pkg::ROW_AW'($signed({1'b0, w_cur}));
				end
			end

			case (state_q)
				ST_IDLE: begin
					if (q_nempty) begin
						clip_q     <= '0;
						res_data_q <= '0;
						clr_q      <= '0;
						case (q_desc.kind)
							grbz_pkg::KIND_DRAW:  state_q <= ST_LOAD;
							grbz_pkg::KIND_READ:  state_q <= ST_RD;
							grbz_pkg::KIND_CLEAR: state_q <= ST_CLR;
							default:              state_q <= ST_DONE;
						endcase
					end
				end
				ST_LOAD: begin
					x_q       <= $signed(cur_q.x0);
					y_q       <= $signed(cur_q.y0);
					rowaddr_q <= y0_prod;
					rowbase_q <= y0_prod;
					b_q       <= '0;
					i_q       <= '0;
					j_q       <= '0;
					state_q   <= ST_PIX;
				end
				ST_PIX: begin
					if (in_b && (cur_q.mode == grbz_pkg::MODE_NIBBLE)) begin
						state_q <= ST_RMW;
					end else if (last_j && last_i && last_b) begin
						state_q <= ST_DONE;
					end
				end
				ST_RMW: begin
					state_q <= (last_j && last_i && last_b) ? ST_DONE : ST_PIX;
				end
				ST_RD: begin
					state_q <= ST_RDW;
				end
				ST_RDW: begin
					res_data_q <= cur_q.rd_ok ? rdata_sel : '0;
					state_q    <= ST_DONE;
				end
				ST_CLR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_last) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign empty         = !out_valid_q;
	assign read_data     = out_data_q;
	assign clipped_count = out_clip_q;

endmodule

[design/glyph_row_blitter_zoom.sv]
`timescale 1ns / 1ps
// glyph_row_blitter_zoom: top level; front, descriptor queue, back and the two
// byte stores. Depends on grbz_pkg, grbz_front, grbz_queue, grbz_back, grbz_ram.
//
//   channel   | handshake         | payload
//   ----------+-------------------+-------------------------------------------
//   config    | cfg_we            | cfg_index, cfg_data
//   command   | push / full       | cmd, target, row_bits, row_index, org_x,
//             |                   | org_y, read_col, read_row
//   result    | empty / pop       | read_data, clipped_count
//
// Draw: a sweep of zoom_x*zoom_y*GLYPH_WIDTH pixels, plus a read-modify-write
// step on the store port for every in-bounds pixel in nibble mode. Read: a
// store read, then a registered capture. Clear: zeroes the store byte by byte,
// 524288 bytes for the frame store and 16384 for the text-line store. Reset
// clears control only; store contents stay undefined until written. Two
// commands queue while the back end works or while a result waits for pop.
module glyph_row_blitter_zoom (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [grbz_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [grbz_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  logic                                push,
	output logic                                full,
	input  logic [grbz_pkg::CMD_W-1:0]          cmd,
	input  logic                                target,
	input  logic [grbz_pkg::BITS_W-1:0]         row_bits,
	input  logic [grbz_pkg::ROW_W-1:0]          row_index,
	input  logic signed [grbz_pkg::ORG_W-1:0]   org_x,
	input  logic signed [grbz_pkg::ORG_W-1:0]   org_y,
	input  logic [grbz_pkg::RCOL_W-1:0]         read_col,
	input  logic [grbz_pkg::RROW_W-1:0]         read_row,
	output logic                                empty,
	input  logic                                pop,
	output logic [grbz_pkg::DATA_W-1:0]         read_data,
	output logic [grbz_pkg::CLIP_W-1:0]         clipped_count
);

	logic                          q_wr;
	logic                          q_rd;
	logic                          q_nempty;
	grbz_pkg::desc_t               wdesc;
	grbz_pkg::desc_t               rdesc;
	grbz_pkg::mem_req_t            mem_req;
	logic [grbz_pkg::DATA_W-1:0]   frame_rdata;
	logic [grbz_pkg::DATA_W-1:0]   text_rdata;

	grbz_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.push      (push),
		.q_full    (full),
		.cmd       (cmd),
		.target    (target),
		.row_bits  (row_bits),
		.row_index (row_index),
		.org_x     (org_x),
		.org_y     (org_y),
		.read_col  (read_col),
		.read_row  (read_row),
		.q_wr      (q_wr),
		.q_desc    (wdesc)
	);

	grbz_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (q_wr),
		.wdesc  (wdesc),
		.full   (full),
		.rd     (q_rd),
		.rdesc  (rdesc),
		.nempty (q_nempty)
	);

	grbz_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.q_nempty      (q_nempty),
		.q_desc        (rdesc),
		.q_rd          (q_rd),
		.mem_req       (mem_req),
		.frame_rdata   (frame_rdata),
		.text_rdata    (text_rdata),
		.empty         (empty),
		.pop           (pop),
		.read_data     (read_data),
		.clipped_count (clipped_count)
	);

	grbz_ram #(
		.WIDTH (grbz_pkg::DATA_W),
		.DEPTH (grbz_pkg::FRAME_DEPTH)
	) u_frame_ram (
		.clk   (clk),
		.we    (mem_req.we_frame),
		.waddr (mem_req.waddr[grbz_pkg::FRAME_AW-1:0]),
		.wdata (mem_req.wdata),
		.raddr (mem_req.raddr[grbz_pkg::FRAME_AW-1:0]),
		.rdata (frame_rdata)
	);

	grbz_ram #(
		.WIDTH (grbz_pkg::DATA_W),
		.DEPTH (grbz_pkg::TEXT_DEPTH)
	) u_text_ram (
		.clk   (clk),
		.we    (mem_req.we_text),
		.waddr (mem_req.waddr[grbz_pkg::TEXT_AW-1:0]),
		.wdata (mem_req.wdata),
		.raddr (mem_req.raddr[grbz_pkg::TEXT_AW-1:0]),
		.rdata (text_rdata)
	);

endmodule

[dv/testbench.sv]
`timescale 1ns / 1ps
// testbench: self-checking bench for glyph_row_blitter_zoom. It holds a byte-exact copy of both
// stores and the registers and checks every result transfer in order. Depends on grbz_pkg and glyph_row_blitter_zoom.
module testbench;
	import grbz_pkg::*;

	localparam logic [CMD_W-1:0] CMD_NONE = 2'd3;
	localparam int N_PHASES        = 12;
	localparam int ITEMS_PER_PHASE = 125;
	localparam int CYCLE_LIMIT     = 6_000_000;

	typedef struct {
		logic [CMD_W-1:0]  cmd;
		logic              target;
		logic [BITS_W-1:0] row_bits;
		logic [ROW_W-1:0]  row_index;
		logic [ORG_W-1:0]  org_x;
		logic [ORG_W-1:0]  org_y;
		logic [RCOL_W-1:0] read_col;
		logic [RROW_W-1:0] read_row;
	} blit_cmd_t;

	typedef struct {
		int                seq;
		logic [CMD_W-1:0]  cmd;
		logic              target;
		logic [DATA_W-1:0] read_data;
		logic [CLIP_W-1:0] clipped;
	} blit_result_t;

	class blit_scoreboard;
		bit [DATA_W-1:0] frame_px [FRAME_DEPTH];
		bit [DATA_W-1:0] text_px [TEXT_DEPTH];
		logic              pixel_mode;
		logic [DATA_W-1:0] fg_color;
		logic [DATA_W-1:0] bg_color;
		logic [ZOOM_W-1:0] zoom_x;
		logic [ZOOM_W-1:0] zoom_y;
		blit_result_t owed[$];
		int n_by_cmd [4];
		int n_cmds;
		int n_results;
		int n_dropped;
		int n_settings;
		int n_errors;

		function new();
			pixel_mode = MODE_BYTE;
			fg_color   = '0;
			bg_color   = '0;
			zoom_x     = ZOOM_MIN;
			zoom_y     = ZOOM_MIN;
		endfunction

		function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
				CFG_PIXEL_MODE: pixel_mode = data[0];
				CFG_FG_COLOR:   fg_color = data;
				CFG_BG_COLOR:   bg_color = data;
				CFG_ZOOM_X:     zoom_x = data[ZOOM_W-1:0];
				CFG_ZOOM_Y:     zoom_y = data[ZOOM_W-1:0];
				default: ;
			endcase
		endfunction

		function int eff_zoom(logic [ZOOM_W-1:0] z);
			if (z < ZOOM_MIN)
				return ZOOM_MIN;
			if (z > ZOOM_MAX)
				return ZOOM_MAX;
			return z;
		endfunction

		// returns 1 when the pixel falls outside the store
		function int put_px(logic tgt, int w, int h, logic [DATA_W-1:0] pix, int x, int y);
			int a;
			logic [DATA_W-1:0] old;
			logic [DATA_W-1:0] nv;
			if (x < 0 || y < 0 || x >= w || y >= h)
				return 1;
			if (pixel_mode == MODE_NIBBLE) begin
				a = y * w + x / 2;
				old = (tgt == TGT_TEXT) ? text_px[a] : frame_px[a];
				if (x % 2 == 0)
					nv = (old & NIB_HI) | (pix & NIB_LO);
				else
					nv = (old & NIB_LO) | (pix & NIB_HI);
			end else begin
				a = y * w + x;
				nv = pix;
			end
			if (tgt == TGT_TEXT)
				text_px[a] = nv;
			else
				frame_px[a] = nv;
			return 0;
		endfunction

		function void note_cmd(blit_cmd_t c);
			blit_result_t r;
			int w, h, zx, zy, ox, oy, b, i, j, a;
			r.seq       = n_cmds;
			r.cmd       = c.cmd;
			r.target    = c.target;
			r.read_data = '0;
			r.clipped   = '0;
			w = (c.target == TGT_TEXT) ? TEXT_WIDTH : FRAME_WIDTH;
			h = (c.target == TGT_TEXT) ? TEXT_HEIGHT : FRAME_HEIGHT;
			case (c.cmd)
				CMD_DRAW: begin
					if (int'(c.row_index) < GLYPH_HEIGHT) begin
						zx = eff_zoom(zoom_x);
						zy = eff_zoom(zoom_y);
						ox = $signed(c.org_x);
						oy = $signed(c.org_y);
						for (b = 0; b < GLYPH_WIDTH; b++)
							for (i = 0; i < zx; i++)
								for (j = 0; j < zy; j++)
									r.clipped += CLIP_W'(put_px(c.target, w, h,
										c.row_bits[b] ? fg_color : bg_color,
										ox + zx * (GLYPH_WIDTH - b) - i,
										oy + zy * int'(c.row_index) + j));
					end
				end
				CMD_READ: begin
					if (int'(c.read_col) < w && int'(c.read_row) < h) begin
						a = int'(c.read_row) * w + int'(c.read_col);
						r.read_data = (c.target == TGT_TEXT) ? text_px[a] : frame_px[a];
					end
				end
				CMD_CLEAR: begin
					if (c.target == TGT_TEXT)
						foreach (text_px[k]) text_px[k] = '0;
					else
						foreach (frame_px[k]) frame_px[k] = '0;
				end
				default: ;
			endcase
			n_dropped += r.clipped;
			n_by_cmd[c.cmd]++;
			n_cmds++;
			owed.push_back(r);
		endfunction

		function void check_result(logic [DATA_W-1:0] rd, logic [CLIP_W-1:0] clip);
			blit_result_t e;
			n_results++;
			if (owed.size() == 0) begin
				n_errors++;
				$display("%0t: result transfer with nothing outstanding: %s %02h clipped %0d",
					$time, "read_data", rd, clip);
				return;
			end
			e = owed.pop_front();
			if (rd !== e.read_data) begin
				n_errors++;
				$display("%0t: item %0d (cmd %0d, target %0d) read_data expected %02h, got %02h",
					$time, e.seq, e.cmd, e.target, e.read_data, rd);
			end
			if (clip !== e.clipped) begin
				n_errors++;
				$display("%0t: item %0d (cmd %0d, target %0d) clipped_count %s %0d, got %0d",
					$time, e.seq, e.cmd, e.target, "expected", e.clipped, clip);
			end
		endfunction

		function int pending();
			return owed.size();
		endfunction
	endclass

	logic                    clk;
	logic                    arst_n;
	logic                    cfg_we;
	logic [CFG_IDX_W-1:0]    cfg_index;
	logic [CFG_DATA_W-1:0]   cfg_data;
	logic                    push;
	logic                    full;
	logic [CMD_W-1:0]        cmd;
	logic                    target;
	logic [BITS_W-1:0]       row_bits;
	logic [ROW_W-1:0]        row_index;
	logic signed [ORG_W-1:0] org_x;
	logic signed [ORG_W-1:0] org_y;
	logic [RCOL_W-1:0]       read_col;
	logic [RROW_W-1:0]       read_row;
	logic                    empty;
	logic                    pop;
	logic [DATA_W-1:0]       read_data;
	logic [CLIP_W-1:0]       clipped_count;

	bit no_gaps;
	blit_scoreboard sb = new();

	glyph_row_blitter_zoom dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.push          (push),
		.full          (full),
		.cmd           (cmd),
		.target        (target),
		.row_bits      (row_bits),
		.row_index     (row_index),
		.org_x         (org_x),
		.org_y         (org_y),
		.read_col      (read_col),
		.read_row      (read_row),
		.empty         (empty),
		.pop           (pop),
		.read_data     (read_data),
		.clipped_count (clipped_count)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic int pick_gap();
		int r;
		if (no_gaps)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [ZOOM_W-1:0] pick_zoom();
		int r;
		r = $urandom_range(0, 19);
		if (r < 16)
			return ZOOM_W'($urandom_range(ZOOM_MIN, ZOOM_MAX));
		if (r < 18)
			return '0;
		return ZOOM_W'($urandom_range(ZOOM_MAX + 1, (1 << ZOOM_W) - 1));
	endfunction

	function automatic int in_range(int v, int hi);
		if (v < 0)
			return 0;
		return (v > hi) ? hi : v;
	endfunction

	function automatic blit_cmd_t make_cmd(logic [CMD_W-1:0] op, logic tgt,
			logic [BITS_W-1:0] bits, logic [ROW_W-1:0] row, int ox, int oy, int col, int rrow);
		blit_cmd_t c;
		c.cmd       = op;
		c.target    = tgt;
		c.row_bits  = bits;
		c.row_index = row;
		c.org_x     = ORG_W'(ox);
		c.org_y     = ORG_W'(oy);
		c.read_col  = RCOL_W'(col);
		c.read_row  = RROW_W'(rrow);
		return c;
	endfunction

	// called at a rising edge; returns at the edge of the transfer
	task automatic issue(input blit_cmd_t c);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd       <= c.cmd;
		target    <= c.target;
		row_bits  <= c.row_bits;
		row_index <= c.row_index;
		org_x     <= c.org_x;
		org_y     <= c.org_y;
		read_col  <= c.read_col;
		read_row  <= c.read_row;
		push      <= 1'b1;
		do
			@(posedge clk);
		while (full);
		sb.note_cmd(c);
	endtask

	task automatic settle();
		push <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		sb.set_reg(idx, data);
		@(posedge clk);
	endtask

	task automatic apply_settings(input logic mode, input logic [DATA_W-1:0] fgc,
			input logic [DATA_W-1:0] bgc, input logic [ZOOM_W-1:0] zx, input logic [ZOOM_W-1:0] zy);
		settle();
		write_reg(CFG_PIXEL_MODE, CFG_DATA_W'(mode));
		write_reg(CFG_FG_COLOR, fgc);
		write_reg(CFG_BG_COLOR, bgc);
		write_reg(CFG_ZOOM_X, CFG_DATA_W'(zx));
		write_reg(CFG_ZOOM_Y, CFG_DATA_W'(zy));
		cfg_we <= 1'b0;
		sb.n_settings++;
	endtask

	initial begin : drain
		int stall;
		stall = 0;
		pop <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (pop && !empty) begin
				sb.check_result(read_data, clipped_count);
				stall = pick_gap();
			end
			if (stall > 0) begin
				pop <= 1'b0;
				stall--;
			end else
				pop <= 1'b1;
		end
	end

	initial begin : watchdog
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("timeout after %0d cycles, %0d results outstanding", CYCLE_LIMIT, sb.pending());
		$display("CHECKS FAILED");
		$finish;
	end

	initial begin : stimulus
		blit_cmd_t c;
		int phase, n, r, v, hx, fhy, thy, hy, zyv;
		logic main_tgt;
		arst_n    <= 1'b0;
		cfg_we    <= 1'b0;
		cfg_index <= '0;
		cfg_data  <= '0;
		push      <= 1'b0;
		cmd       <= CMD_DRAW;
		target    <= TGT_FRAME;
		row_bits  <= '0;
		row_index <= '0;
		org_x     <= '0;
		org_y     <= '0;
		read_col  <= '0;
		read_row  <= '0;
		no_gaps = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// both stores start undefined, so clear them before anything reads or merges
		issue(make_cmd(CMD_CLEAR, TGT_FRAME, 8'h00, 3'd0, 0, 0, 0, 0));
		issue(make_cmd(CMD_CLEAR, TGT_TEXT, 8'h00, 3'd0, 0, 0, 0, 0));
		issue(make_cmd(CMD_DRAW, TGT_FRAME, 8'h81, 3'd0, 0, 0, 0, 0));

		apply_settings(MODE_BYTE, 8'hff, 8'h00, ZOOM_MAX, ZOOM_MAX);
		issue(make_cmd(CMD_DRAW, TGT_FRAME, 8'hff, 3'd7, 0, 0, 0, 0));
		issue(make_cmd(CMD_DRAW, TGT_FRAME, 8'h00, 3'd0, -2048, -2048, 0, 0));
		issue(make_cmd(CMD_DRAW, TGT_FRAME, 8'ha5, 3'd3, 2047, 2047, 0, 0));
		issue(make_cmd(CMD_DRAW, TGT_FRAME, 8'h5a, 3'd1, -20, 505, 0, 0));
		issue(make_cmd(CMD_READ, TGT_FRAME, 8'h00, 3'd0, 0, 0, 32, 28));
		issue(make_cmd(CMD_READ, TGT_FRAME, 8'hff, 3'd7, 0, 0, 1023, 511));
		issue(make_cmd(CMD_READ, TGT_TEXT, 8'h00, 3'd0, 0, 0, 0, 511));
		issue(make_cmd(CMD_NONE, TGT_TEXT, 8'hff, 3'd7, -1, -1, 1023, 511));
		issue(make_cmd(CMD_DRAW, TGT_TEXT, 8'h3c, 3'd2, 1000, 4, 0, 0));

		// nibble packing with zooms outside the legal range
		apply_settings(MODE_NIBBLE, 8'ha5, 8'h3c, 3'd0, 3'd7);
		issue(make_cmd(CMD_DRAW, TGT_TEXT, 8'h55, 3'd0, 1, 14, 0, 0));
		issue(make_cmd(CMD_DRAW, TGT_TEXT, 8'haa, 3'd0, 0, 14, 0, 0));
		issue(make_cmd(CMD_READ, TGT_TEXT, 8'h00, 3'd0, 0, 0, 1, 14));
		issue(make_cmd(CMD_READ, TGT_TEXT, 8'h00, 3'd0, 0, 0, 4, 15));
		issue(make_cmd(CMD_READ, TGT_TEXT, 8'h00, 3'd0, 0, 0, 0, 16));

		apply_settings(MODE_NIBBLE, 8'h0f, 8'hf0, 3'd5, 3'd0);
		issue(make_cmd(CMD_DRAW, TGT_FRAME, 8'hf0, 3'd5, -3, 0, 0, 0));
		issue(make_cmd(CMD_READ, TGT_FRAME, 8'h00, 3'd0, 0, 0, 0, 5));
		issue(make_cmd(CMD_READ, TGT_FRAME, 8'h00, 3'd0, 0, 0, 14, 5));
		issue(make_cmd(CMD_CLEAR, TGT_TEXT, 8'h00, 3'd0, 0, 0, 0, 0));
		issue(make_cmd(CMD_READ, TGT_TEXT, 8'h00, 3'd0, 0, 0, 1, 14));

		for (phase = 0; phase < N_PHASES; phase++) begin
			no_gaps = 1'b0;
			case (phase)
				0: apply_settings(MODE_BYTE, 8'hff, 8'h00, ZOOM_MAX, ZOOM_MAX);
				1: apply_settings(MODE_NIBBLE, 8'h00, 8'hff, ZOOM_MIN, ZOOM_MIN);
				2: apply_settings(MODE_NIBBLE, 8'hff, 8'hff, 3'd0, 3'd7);
				3: apply_settings(MODE_BYTE, 8'h00, 8'h00, 3'd7, 3'd0);
				default: apply_settings(1'($urandom_range(0, 1)), DATA_W'($urandom),
					DATA_W'($urandom), pick_zoom(), pick_zoom());
			endcase
			no_gaps = (phase % 4 == 3);
			main_tgt = 1'($urandom_range(0, 1));
			case ($urandom_range(0, 2))
				0: hx = 0;
				1: hx = FRAME_WIDTH - 8;
				default: hx = $urandom_range(0, FRAME_WIDTH - 1);
			endcase
			case ($urandom_range(0, 2))
				0: fhy = 0;
				1: fhy = FRAME_HEIGHT - 4;
				default: fhy = $urandom_range(0, FRAME_HEIGHT - 1);
			endcase
			thy = $urandom_range(0, TEXT_HEIGHT - 1);
			zyv = sb.eff_zoom(sb.zoom_y);
			for (n = 0; n < ITEMS_PER_PHASE; n++) begin
				c.target    = ($urandom_range(0, 3) == 0) ? ~main_tgt : main_tgt;
				c.row_bits  = BITS_W'($urandom);
				c.row_index = ROW_W'($urandom);
				c.org_x     = ORG_W'($urandom);
				c.org_y     = ORG_W'($urandom);
				c.read_col  = RCOL_W'($urandom);
				c.read_row  = RROW_W'($urandom);
				hy = (c.target == TGT_TEXT) ? thy : fhy;
				r = $urandom_range(0, 999);
				if (r < 620) begin
					c.cmd   = CMD_DRAW;
					c.org_x = ORG_W'(hx - 24 + int'($urandom_range(0, 48)));
					c.org_y = ORG_W'(hy - zyv * int'(c.row_index) - 4 + int'($urandom_range(0, 8)));
				end else if (r < 670)
					c.cmd = CMD_DRAW;
				else if (r < 920) begin
					c.cmd = CMD_READ;
					v = hx - 24 + int'($urandom_range(0, 80));
					if (sb.pixel_mode == MODE_NIBBLE)
						v = v / 2;
					c.read_col = RCOL_W'(in_range(v, (1 << RCOL_W) - 1));
					c.read_row = RROW_W'(in_range(hy - 4 + int'($urandom_range(0, 8)),
						(1 << RROW_W) - 1));
				end else if (r < 970)
					c.cmd = CMD_READ;
				else if (r < 993)
					c.cmd = CMD_NONE;
				else begin
					// a frame clear writes 524288 bytes, so only the text store here
					c.cmd    = CMD_CLEAR;
					c.target = TGT_TEXT;
				end
				issue(c);
			end
		end

		settle();
		repeat (20) @(posedge clk);
		$display("Run covered %0d commands: %0d draws (%0d pixels dropped), %0d reads,",
			sb.n_cmds, sb.n_by_cmd[CMD_DRAW], sb.n_dropped, sb.n_by_cmd[CMD_READ]);
		$display("%0d clears, %0d no-ops, %0d register settings, %0d result transfers checked",
			sb.n_by_cmd[CMD_CLEAR], sb.n_by_cmd[CMD_NONE], sb.n_settings, sb.n_results);
		if (sb.n_errors == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
